>>> rtl/core/e2sw_pkg.sv
`default_nettype none

package e2sw_pkg;

    // encoder and fixed point format
    localparam int COUNT_BITS = 12;
    localparam int FRAC_BITS  = 16;

    // field and register widths
    localparam int DELTA_W    = COUNT_BITS + 1;
    localparam int GAIN_W     = 24;
    localparam int HLIMIT_W   = 12;
    localparam int LLIMIT_W   = 7;
    localparam int STEP_MAX_W = 7;
    localparam int SPIKE_W    = 12;
    localparam int STEP_W     = 8;

    // datapath widths
    localparam int RAW_W   = COUNT_BITS + 2;
    localparam int CMP_W   = ((RAW_W > SPIKE_W) ? RAW_W : SPIKE_W) + 1;
    localparam int PROD_W  = DELTA_W + GAIN_W + 1;
    localparam int ACC_W   = HLIMIT_W + FRAC_BITS + 1;
    localparam int SUM_W   = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
    localparam int LIM_W   = HLIMIT_W + FRAC_BITS;
    localparam int WHOLE_W = ACC_W - 1 - FRAC_BITS;

    // stream widths
    localparam int IN_DATA_W  = ((COUNT_BITS + 7) / 8) * 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = ((STEP_W + DELTA_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 1;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIRES_GAIN     = 3'd0,
        CFG_LINE_GAIN      = 3'd1,
        CFG_HIRES_LIMIT    = 3'd2,
        CFG_LINE_LIMIT     = 3'd3,
        CFG_MAX_HIRES_STEP = 3'd4,
        CFG_SPIKE_LIMIT    = 3'd5
    } cfg_index_t;

    localparam logic [GAIN_W-1:0]     RST_HIRES_GAIN     = 24'd46080;
    localparam logic [GAIN_W-1:0]     RST_LINE_GAIN      = 24'd384;
    localparam logic [HLIMIT_W-1:0]   RST_HIRES_LIMIT    = 12'd240;
    localparam logic [LLIMIT_W-1:0]   RST_LINE_LIMIT     = 7'd4;
    localparam logic [STEP_MAX_W-1:0] RST_MAX_HIRES_STEP = 7'd127;
    localparam logic [SPIKE_W-1:0]    RST_SPIKE_LIMIT    = 12'd300;

endpackage

`default_nettype wire

>>> rtl/core/encoder_to_scroll_wheel.sv
`default_nettype none

// Encoder angle to scroll wheel converter.
// Slave stream: one beat per encoder sample. s_tdata[11:0] angle_count,
// s_tuser[0] link_up, s_tuser[1] hires_mode.
// Master stream: one beat per sample. m_tdata[7:0] scroll_step (signed, already
// negated, 0 = nothing to send), m_tdata[20:8] count_delta (signed),
// m_tuser[0] spike_seen.
// Config: cfg_we/cfg_index/cfg_data write one register per cycle; write only
// while no sample is in flight.
// Pipeline: m_tvalid comes from the output register (input register loads at
// the accepting edge, then delta/product register, then output register).
// Throughput: one beat per cycle while the master side does not stall.
// The accumulator add, clamp and extraction close their loop in stage 2.
// Reset: registers go to their default values, the first sample after reset
// only primes the stored angle, the accumulator is zero.
// Stall: each stage holds while the one after it is full and stalled; a
// sample is still taken while a result waits on the master side as long as
// an earlier stage is empty.
module encoder_to_scroll_wheel (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [e2sw_pkg::IN_DATA_W-1:0]    s_tdata,   // angle_count
    input  logic [e2sw_pkg::IN_USER_W-1:0]    s_tuser,   // link_up, hires_mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [e2sw_pkg::OUT_DATA_W-1:0]   m_tdata,   // scroll_step, count_delta
    output logic [e2sw_pkg::OUT_USER_W-1:0]   m_tuser,   // spike_seen
    input  logic                              cfg_we,
    input  logic [e2sw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [e2sw_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import e2sw_pkg::*;

    localparam logic signed [RAW_W-1:0] HALF_TURN = RAW_W'(2 ** (COUNT_BITS - 1));
    localparam logic signed [RAW_W-1:0] FULL_REV = RAW_W'(2 ** COUNT_BITS);

    // configuration registers
    logic [GAIN_W-1:0]     hires_gain_reg;
    logic [GAIN_W-1:0]     line_gain_reg;
    logic [HLIMIT_W-1:0]   hires_limit_reg;
    logic [LLIMIT_W-1:0]   line_limit_reg;
    logic [STEP_MAX_W-1:0] max_step_reg;
    logic [SPIKE_W-1:0]    spike_limit_reg;

    // state
    logic [COUNT_BITS-1:0]   prev_count_reg;
    logic                    primed_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    // stage 1: input register
    logic                  s1_valid_reg;
    logic [COUNT_BITS-1:0] s1_count_reg;
    logic                  s1_link_reg;
    logic                  s1_hires_reg;

    // stage 2: delta and product
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic                     s2_active_reg;
    logic                     s2_hires_reg;
    logic                     s2_spike_reg;
    logic [DELTA_W-1:0]       s2_delta_reg;

    // output register
    logic                m_valid_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                spike_reg;
    logic [DELTA_W-1:0]  delta_reg;

    logic s1_ready;
    logic s2_ready;
    logic out_ready;

    assign out_ready = !m_valid_reg || m_tready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_tready  = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hires_gain_reg  <= RST_HIRES_GAIN;
            line_gain_reg   <= RST_LINE_GAIN;
            hires_limit_reg <= RST_HIRES_LIMIT;
            line_limit_reg  <= RST_LINE_LIMIT;
            max_step_reg    <= RST_MAX_HIRES_STEP;
            spike_limit_reg <= RST_SPIKE_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HIRES_GAIN:     hires_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_LINE_GAIN:      line_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_HIRES_LIMIT:    hires_limit_reg <= cfg_data[HLIMIT_W-1:0];
                CFG_LINE_LIMIT:     line_limit_reg  <= cfg_data[LLIMIT_W-1:0];
                CFG_MAX_HIRES_STEP: max_step_reg    <= cfg_data[STEP_MAX_W-1:0];
                CFG_SPIKE_LIMIT:    spike_limit_reg <= cfg_data[SPIKE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s1_ready)
        begin
            s1_count_reg <= s_tdata[COUNT_BITS-1:0];
            s1_link_reg  <= s_tuser[0];
            s1_hires_reg <= s_tuser[1];
        end
    end

    logic signed [RAW_W-1:0]  raw_diff;
    logic signed [RAW_W-1:0]  wrap_diff;
    logic signed [CMP_W-1:0]  diff_x;
    logic signed [CMP_W-1:0]  spike_lim_x;
    logic                     spike;
    logic signed [DELTA_W-1:0] delta;
    logic [GAIN_W-1:0]        gain;
    logic signed [PROD_W-1:0] prod;
    logic                     active;

    always_comb
    begin
        raw_diff = signed'({2'b00, s1_count_reg}) - signed'({2'b00, prev_count_reg});
        if (raw_diff > HALF_TURN)
            wrap_diff = raw_diff - FULL_REV;
        else if (raw_diff < -HALF_TURN)
            wrap_diff = raw_diff + FULL_REV;
        else
            wrap_diff = raw_diff;

        diff_x      = CMP_W'(wrap_diff);
        spike_lim_x = signed'(CMP_W'(spike_limit_reg));
        spike       = primed_reg && (diff_x > spike_lim_x || diff_x < -spike_lim_x);

        if (primed_reg && !spike)
            delta = wrap_diff[DELTA_W-1:0];
        else
            delta = '0;

        gain   = s1_hires_reg ? hires_gain_reg : line_gain_reg;
        prod   = PROD_W'(delta) * signed'(PROD_W'(gain));
        active = (delta != '0) && s1_link_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg   <= 1'b0;
            prev_count_reg <= '0;
            primed_reg     <= 1'b0;
        end
        else
        begin
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg && s2_ready)
            begin
                prev_count_reg <= s1_count_reg;
                primed_reg     <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_prod_reg   <= prod;
            s2_active_reg <= active;
            s2_hires_reg  <= s1_hires_reg;
            s2_spike_reg  <= spike;
            s2_delta_reg  <= delta;
        end
    end

    // ---------------- stage 2 ----------------
    logic signed [SUM_W-1:0]  acc_sum;
    logic [LIM_W-1:0]         lim_u;
    logic signed [SUM_W-1:0]  lim_s;
    logic signed [SUM_W-1:0]  acc_clamped;
    logic signed [ACC_W-1:0]  acc_c;
    logic                     acc_neg;
    logic [ACC_W-2:0]         acc_mag;
    logic [WHOLE_W-1:0]       whole;
    logic [STEP_MAX_W-1:0]    take;
    logic signed [ACC_W-1:0]  take_fix;
    logic [STEP_W-1:0]        step;

    always_comb
    begin
        acc_sum = SUM_W'(acc_reg) + SUM_W'(s2_prod_reg);
        if (s2_hires_reg)
            lim_u = {hires_limit_reg, {FRAC_BITS{1'b0}}};
        else
            lim_u = {HLIMIT_W'(line_limit_reg), {FRAC_BITS{1'b0}}};
        lim_s = signed'(SUM_W'(lim_u));

        if (acc_sum > lim_s)
            acc_clamped = lim_s;
        else if (acc_sum < -lim_s)
            acc_clamped = -lim_s;
        else
            acc_clamped = acc_sum;
        acc_c = acc_clamped[ACC_W-1:0];

        acc_neg = acc_c[ACC_W-1];
        if (acc_neg)
            acc_mag = (ACC_W-1)'(-acc_c);
        else
            acc_mag = acc_c[ACC_W-2:0];
        whole = acc_mag[ACC_W-2:FRAC_BITS];

        // truncation toward zero: whole units of the magnitude
        if (s2_hires_reg)
        begin
            if (whole > WHOLE_W'(max_step_reg))
                take = max_step_reg;
            else
                take = whole[STEP_MAX_W-1:0];
        end
        else
        begin
            take = (whole != '0) ? STEP_MAX_W'(1) : '0;
        end

        take_fix = signed'({(ACC_W-STEP_MAX_W-FRAC_BITS)'(0), take, {FRAC_BITS{1'b0}}});
        if (acc_neg)
        begin
            acc_next = acc_c + take_fix;
            step     = STEP_W'(take);
        end
        else
        begin
            acc_next = acc_c - take_fix;
            step     = -STEP_W'(take);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            if (out_ready)
                m_valid_reg <= s2_valid_reg;
            if (s2_valid_reg && out_ready && s2_active_reg)
                acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && out_ready)
        begin
            step_reg  <= s2_active_reg ? step : '0;
            spike_reg <= s2_spike_reg;
            delta_reg <= s2_delta_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'({delta_reg, step_reg});
    assign m_tuser  = OUT_USER_W'(spike_reg);

endmodule

`default_nettype wire

>>> rtl/core/e2sw_checker.sv
`default_nettype none

module e2sw_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [e2sw_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic [e2sw_pkg::OUT_USER_W-1:0]   m_tuser
);
    import e2sw_pkg::*;

    logic [STEP_W-1:0]  step;
    logic [DELTA_W-1:0] delta;

    assign step  = m_tdata[STEP_W-1:0];
    assign delta = m_tdata[STEP_W+DELTA_W-1:STEP_W];

    // no result beat while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("m_tvalid high during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // a dropped jump reports no delta and no step
    a_spike_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> delta == '0 && step == '0)
        else $error("spike beat carries delta or step");

    // a step only follows real motion
    a_step_needs_delta: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && step != '0 |-> delta != '0)
        else $error("step without count delta");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> step != {1'b1, {(STEP_W-1){1'b0}}})
        else $error("scroll step out of range");

endmodule

bind encoder_to_scroll_wheel e2sw_checker u_e2sw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
